// File: hdl/cpa_pkg.sv
// ----------------------------------------------------------------------------
// Contiguous page allocator package
// Shared constants, status codes, register indexes and the configuration
// record that the top level hands to the sequencer.
// ----------------------------------------------------------------------------
package cpa_pkg;

	// Field widths of the channels and of the configuration port.
	localparam int STATUS_W    = 3;
	localparam int ADDR_W      = 32;
	localparam int SIZE_W      = 32;
	localparam int PAGES_OUT_W = 11;
	localparam int PAGE_NUM_W  = 20;
	localparam int SMALL_W     = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 20;

	// Operation codes of an input beat.
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// Status codes of a result beat.
	localparam logic [STATUS_W-1:0] STS_ALLOCATED   = 3'd0;
	localparam logic [STATUS_W-1:0] STS_NO_SPACE    = 3'd1;
	localparam logic [STATUS_W-1:0] STS_SMALL       = 3'd2;
	localparam logic [STATUS_W-1:0] STS_FREED       = 3'd3;
	localparam logic [STATUS_W-1:0] STS_BLOCK_FREE  = 3'd4;
	localparam logic [STATUS_W-1:0] STS_INVALID     = 3'd5;
	localparam logic [STATUS_W-1:0] STS_NOT_ALLOC   = 3'd6;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_START = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LIMIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SMALL_LIMIT = 2'd2;

	// Reset value of the small-size limit.
	localparam logic [SMALL_W-1:0] SMALL_LIMIT_RST = 16'd2048;

	// Configuration as seen by the sequencer.
	typedef struct packed {
		logic [PAGE_NUM_W-1:0] block_start_page;
		logic [PAGE_NUM_W-1:0] block_limit_page;
		logic [SMALL_W-1:0]    small_size_limit;
	} cfg_t;

endpackage

// File: hdl/cpa_if.sv
// ----------------------------------------------------------------------------
// Contiguous page allocator channel interfaces
// Request and response channels, each with valid, ready and payload.
// ----------------------------------------------------------------------------
interface cpa_req_if import cpa_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              operation;
	logic [SIZE_W-1:0] size_bytes;
	logic [ADDR_W-1:0] address;

	modport source (output valid, operation, size_bytes, address, input ready);
	modport sink   (input valid, operation, size_bytes, address, output ready);
endinterface

interface cpa_rsp_if import cpa_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [STATUS_W-1:0]    status;
	logic [ADDR_W-1:0]      result_address;
	logic [PAGES_OUT_W-1:0] pages_changed;

	modport source (output valid, status, result_address, pages_changed, input ready);
	modport sink   (input valid, status, result_address, pages_changed, output ready);
endinterface

// File: hdl/contiguous_page_allocator_top.sv
// ----------------------------------------------------------------------------
// Contiguous page allocator
// First-fit allocator of contiguous page runs above the block region.
// ----------------------------------------------------------------------------
// After reset the block sweeps the slot memory, one slot a cycle, and
// takes no request meanwhile; configuration writes are taken at once. It
// then handles one request at a time with a single probe unit that reads
// slot records one by one from a one-read, one-write memory. An allocation
// probes slots until a fit is found, at most the usable slot count and
// fewer when used runs are skipped, then marks the pages of the run. A free
// reads the addressed slot record and clears its run if it is used; small
// requests, block-region frees and invalid addresses finish without a
// probe. A finished result waits in the output register until it is taken.
module contiguous_page_allocator_top import cpa_pkg::*; #(
	parameter int PAGE_SLOTS = 1024,
	parameter int PAGE_BYTES = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	cpa_req_if.sink               req,
	cpa_rsp_if.source             rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int SLOT_W = $clog2(PAGE_SLOTS);
	localparam int ENT_W  = 2 * SLOT_W + 2;

	cfg_t              cfg_q;
	logic              mem_we;
	logic [SLOT_W-1:0] mem_waddr;
	logic [ENT_W-1:0]  mem_wdata;
	logic [SLOT_W-1:0] mem_raddr;
	logic [ENT_W-1:0]  mem_rdata;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.block_start_page <= '0;
			cfg_q.block_limit_page <= '0;
			cfg_q.small_size_limit <= SMALL_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BLOCK_START: cfg_q.block_start_page <= cfg_wdata;
				CFG_BLOCK_LIMIT: cfg_q.block_limit_page <= cfg_wdata;
				CFG_SMALL_LIMIT: cfg_q.small_size_limit <= cfg_wdata[SMALL_W-1:0];
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	// Sequencer and probe unit.
	cpa_seq #(
		.PAGE_SLOTS (PAGE_SLOTS),
		.PAGE_BYTES (PAGE_BYTES)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.req       (req),
		.rsp       (rsp),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	// Slot record memory.
	cpa_slot_mem #(
		.DEPTH (PAGE_SLOTS),
		.WIDTH (ENT_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Ready is low in the cycle after a request beat.
	assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request taken on the cycle after a request beat");

	// Only an allocation carries an address.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != STS_ALLOCATED |-> rsp.result_address == '0)
		else $error("non-zero address on a result that is not an allocation");

	// Page counts appear only on allocations and frees.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != STS_ALLOCATED && rsp.status != STS_FREED
		|-> rsp.pages_changed == '0)
		else $error("page count on a result that changed nothing");

	// A successful allocation always covers at least one page.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == STS_ALLOCATED |-> rsp.pages_changed != '0)
		else $error("allocation reported with no pages");

endmodule

// File: hdl/cpa_slot_mem.sv
// ----------------------------------------------------------------------------
// Slot record memory
// One write port and one read port with registered read data. Each entry
// holds the used flag, the run start and the run length of one page slot.
// ----------------------------------------------------------------------------
module cpa_slot_mem #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 22
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// File: hdl/cpa_seq.sv
// ----------------------------------------------------------------------------
// Allocator sequencer
// Classifies each request, then walks the slot memory one probe at a time
// for a first-fit search, a run marking pass or a run release pass.
// ----------------------------------------------------------------------------
module cpa_seq import cpa_pkg::*; #(
	parameter int PAGE_SLOTS = 1024,
	parameter int PAGE_BYTES = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cfg_t                          cfg,
	cpa_req_if.sink                       req,
	cpa_rsp_if.source                     rsp,
	output logic                          mem_we,
	output logic [$clog2(PAGE_SLOTS)-1:0] mem_waddr,
	output logic [2*$clog2(PAGE_SLOTS)+1:0] mem_wdata,
	output logic [$clog2(PAGE_SLOTS)-1:0] mem_raddr,
	input  logic [2*$clog2(PAGE_SLOTS)+1:0] mem_rdata
);

	localparam int SLOT_W     = $clog2(PAGE_SLOTS);
	localparam int LEN_W      = SLOT_W + 1;
	localparam int ENT_W      = 1 + SLOT_W + LEN_W;
	localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
	localparam int APG_W      = ADDR_W - PAGE_SHIFT;
	localparam int PN_BASE    = (APG_W + 1 > PAGE_NUM_W + 1) ? APG_W + 1 : PAGE_NUM_W + 1;
	localparam int PN_W       = PN_BASE + 1;

	localparam logic [PN_W-1:0]   TOP_PAGE  = PN_W'(1) << APG_W;
	localparam logic [PN_W-1:0]   SLOTS_PN  = PN_W'(PAGE_SLOTS);
	localparam logic [LEN_W-1:0]  LAST_SLOT = LEN_W'(PAGE_SLOTS - 1);
	localparam logic [LEN_W-1:0]  ONE_LEN   = LEN_W'(1);

	// Sequencer states.
	localparam logic [3:0] S_CLEAR  = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_SETUP  = 4'd2;
	localparam logic [3:0] S_CLASS  = 4'd3;
	localparam logic [3:0] S_A_RD   = 4'd4;
	localparam logic [3:0] S_A_EV   = 4'd5;
	localparam logic [3:0] S_A_MARK = 4'd6;
	localparam logic [3:0] S_F_RD   = 4'd7;
	localparam logic [3:0] S_F_EV   = 4'd8;
	localparam logic [3:0] S_F_CLR  = 4'd9;
	localparam logic [3:0] S_DONE   = 4'd10;

	logic [3:0]             state_q;
	logic [LEN_W-1:0]       idx_q;
	logic [SLOT_W-1:0]      first_q;
	logic [LEN_W-1:0]       run_q;
	logic [LEN_W-1:0]       pages_q;
	logic [LEN_W-1:0]       usable_q;
	logic                   op_q;
	logic [SIZE_W-1:0]      size_q;
	logic [ADDR_W-1:0]      addr_q;
	logic [STATUS_W-1:0]    res_status_q;
	logic [ADDR_W-1:0]      res_addr_q;
	logic [LEN_W-1:0]       res_pages_q;
	logic                   out_valid_q;
	logic [STATUS_W-1:0]    out_status_q;
	logic [ADDR_W-1:0]      out_addr_q;
	logic [PAGES_OUT_W-1:0] out_pages_q;

	// Page-number arithmetic on the configuration and the request.
	logic [PN_W-1:0]           base_pg;
	logic [PN_W-1:0]           usable_pg;
	logic [PN_W-1:0]           addr_pg;
	logic [PN_W-1:0]           end_pg;
	logic [PN_W-1:0]           slot_pg;
	logic [PN_W-1:0]           req_pages;
	logic [SIZE_W:0]           size_round;
	logic [PN_W-1:0]           run_base_pg;
	logic [LEN_W+PAGES_OUT_W-1:0] pages_ext;

	// Fields of the slot record that comes back from memory.
	logic                   rd_used;
	logic [SLOT_W-1:0]      rd_start;
	logic [LEN_W-1:0]       rd_len;
	logic [LEN_W-1:0]       run_next;

	assign rd_used  = mem_rdata[ENT_W-1];
	assign rd_start = mem_rdata[LEN_W +: SLOT_W];
	assign rd_len   = mem_rdata[LEN_W-1:0];
	assign run_next = run_q + ONE_LEN;

	// Number of slots that sit wholly below the top of the address space.
	always_comb begin
		base_pg = PN_W'(cfg.block_limit_page) + PN_W'(1);
		if (base_pg >= TOP_PAGE) begin
			usable_pg = '0;
		end else if (TOP_PAGE - base_pg < SLOTS_PN) begin
			usable_pg = TOP_PAGE - base_pg;
		end else begin
			usable_pg = SLOTS_PN;
		end
	end

	// Request decoding in page units.
	always_comb begin
		addr_pg     = PN_W'(addr_q[ADDR_W-1:PAGE_SHIFT]);
		end_pg      = base_pg + PN_W'(usable_q);
		slot_pg     = addr_pg - base_pg;
		size_round  = {1'b0, size_q} + (SIZE_W+1)'(PAGE_BYTES - 1);
		req_pages   = PN_W'(size_round[SIZE_W:PAGE_SHIFT]);
		run_base_pg = base_pg + PN_W'(first_q);
		pages_ext   = {{PAGES_OUT_W{1'b0}}, res_pages_q};
	end

	// Memory port control.
	always_comb begin
		mem_we    = 1'b0;
		mem_wdata = '0;
		mem_waddr = idx_q[SLOT_W-1:0];
		mem_raddr = idx_q[SLOT_W-1:0];
		case (state_q)
			S_CLEAR, S_F_CLR: begin
				mem_we = 1'b1;
			end
			S_A_MARK: begin
				mem_we    = 1'b1;
				mem_wdata = {1'b1, first_q, pages_q};
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	assign req.ready          = (state_q == S_IDLE);
	assign rsp.valid          = out_valid_q;
	assign rsp.status         = out_status_q;
	assign rsp.result_address = out_addr_q;
	assign rsp.pages_changed  = out_pages_q;

	// Control: state, slot index and the output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && rsp.ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					if (idx_q == LAST_SLOT) begin
						state_q <= S_IDLE;
					end
					idx_q <= idx_q + ONE_LEN;
				end
				S_IDLE: begin
					if (req.valid) begin
						state_q <= S_SETUP;
					end
				end
				S_SETUP: begin
					state_q <= S_CLASS;
				end
				S_CLASS: begin
					state_q <= S_DONE;
					idx_q   <= '0;
					if (op_q == OP_ALLOC) begin
						if (size_q > SIZE_W'(cfg.small_size_limit) &&
						    req_pages <= PN_W'(usable_q)) begin
							state_q <= S_A_RD;
						end
					end else if (!(addr_pg >= PN_W'(cfg.block_start_page) &&
					               addr_pg < PN_W'(cfg.block_limit_page)) &&
					             addr_pg >= base_pg && addr_pg < end_pg) begin
						state_q <= S_F_RD;
						idx_q   <= slot_pg[LEN_W-1:0];
					end
				end
				S_A_RD: begin
					state_q <= (idx_q >= usable_q) ? S_DONE : S_A_EV;
				end
				S_A_EV: begin
					if (rd_used) begin
						idx_q   <= idx_q + ((rd_len == '0) ? ONE_LEN : rd_len);
						state_q <= S_A_RD;
					end else if (run_next == pages_q) begin
						idx_q   <= (run_q == '0) ? idx_q : LEN_W'(first_q);
						state_q <= S_A_MARK;
					end else begin
						idx_q   <= idx_q + ONE_LEN;
						state_q <= S_A_RD;
					end
				end
				S_A_MARK: begin
					idx_q <= idx_q + ONE_LEN;
					if (run_q == ONE_LEN) begin
						state_q <= S_DONE;
					end
				end
				S_F_RD: begin
					state_q <= S_F_EV;
				end
				S_F_EV: begin
					if (!rd_used || rd_len == '0) begin
						state_q <= S_DONE;
					end else begin
						idx_q   <= LEN_W'(rd_start);
						state_q <= S_F_CLR;
					end
				end
				S_F_CLR: begin
					idx_q <= idx_q + ONE_LEN;
					if (run_q == ONE_LEN || idx_q == LAST_SLOT) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath: request fields, search counters and result fields.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q   <= req.operation;
				size_q <= req.size_bytes;
				addr_q <= req.address;
			end
			S_SETUP: begin
				usable_q     <= usable_pg[LEN_W-1:0];
				res_addr_q   <= '0;
				res_pages_q  <= '0;
			end
			S_CLASS: begin
				run_q   <= '0;
				pages_q <= req_pages[LEN_W-1:0];
				if (op_q == OP_ALLOC) begin
					if (size_q <= SIZE_W'(cfg.small_size_limit)) begin
						res_status_q <= STS_SMALL;
					end else begin
						res_status_q <= STS_NO_SPACE;
					end
				end else if (addr_pg >= PN_W'(cfg.block_start_page) &&
				             addr_pg < PN_W'(cfg.block_limit_page)) begin
					res_status_q <= STS_BLOCK_FREE;
				end else if (addr_pg < base_pg || addr_pg >= end_pg) begin
					res_status_q <= STS_INVALID;
				end else begin
					res_status_q <= STS_NOT_ALLOC;
				end
			end
			S_A_EV: begin
				if (rd_used) begin
					run_q <= '0;
				end else begin
					if (run_q == '0) begin
						first_q <= idx_q[SLOT_W-1:0];
					end
					run_q <= run_next;
				end
			end
			S_A_MARK: begin
				run_q <= run_q - ONE_LEN;
				if (run_q == ONE_LEN) begin
					res_status_q <= STS_ALLOCATED;
					res_pages_q  <= pages_q;
					res_addr_q   <= {run_base_pg[APG_W-1:0], {PAGE_SHIFT{1'b0}}};
				end
			end
			S_F_EV: begin
				if (rd_used) begin
					res_status_q <= STS_FREED;
					res_pages_q  <= rd_len;
					run_q        <= rd_len;
				end
			end
			S_F_CLR: begin
				run_q <= run_q - ONE_LEN;
			end
			S_DONE: begin
				if (!out_valid_q || rsp.ready) begin
					out_status_q <= res_status_q;
					out_addr_q   <= res_addr_q;
					out_pages_q  <= pages_ext[PAGES_OUT_W-1:0];
				end
			end
			default: begin
				run_q <= run_q;
			end
		endcase
	end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Contiguous page allocator testbench
// Drives allocate and free requests through the request channel. Each
// accepted request is run through a first-fit model of the page slots
// kept here, and every response beat is checked field by field against it.
// A short directed list covers the edges of the address map and of the
// request sizes. Random traffic follows under several region settings and
// three handshake pressure profiles.
// ----------------------------------------------------------------------------
module testbench;
	import cpa_pkg::*;

	localparam int PAGE_SLOTS     = 1024;
	localparam int PAGE_BYTES     = 4096;
	localparam int WATCHDOG_LIMIT = 50000;
	localparam int PRINT_LIMIT    = 40;
	localparam int PHASE_ITEMS    = 92;

	typedef struct packed {
		logic              op;
		logic [SIZE_W-1:0] size;
		logic [ADDR_W-1:0] addr;
	} request_t;

	typedef struct packed {
		logic [STATUS_W-1:0]    status;
		logic [ADDR_W-1:0]      address;
		logic [PAGES_OUT_W-1:0] pages;
	} outcome_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	cpa_req_if req ();
	cpa_rsp_if rsp ();

	// Model of the slot map and the register copies.
	bit          slot_taken [PAGE_SLOTS];
	int unsigned slot_head  [PAGE_SLOTS];
	int unsigned slot_pages [PAGE_SLOTS];
	logic [PAGE_NUM_W-1:0] region_start;
	logic [PAGE_NUM_W-1:0] region_limit;
	logic [SMALL_W-1:0]    small_bytes;

	request_t request_backlog [$];
	outcome_t awaited_results [$];
	request_t next_beat;
	request_t taken_beat;
	outcome_t due_result;

	int send_idle_pct;
	int recv_idle_pct;
	int error_count;
	int requests_taken;
	int results_checked;
	int quiet_cycles;
	int status_seen [8];

	contiguous_page_allocator_top #(
		.PAGE_SLOTS(PAGE_SLOTS),
		.PAGE_BYTES(PAGE_BYTES)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rsp      (rsp),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// Free-running clock, 10 ns period.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Byte address of page slot 0, one page above the block-region limit.
	function automatic longint unsigned slot_base();
		longint unsigned lim;
		lim = region_limit;
		return (lim + 1) * PAGE_BYTES;
	endfunction

	// Slots that lie wholly below the top of the 32-bit address space.
	function automatic int unsigned usable_slots();
		longint unsigned base_addr, fit;
		base_addr = slot_base();
		if (base_addr >= 64'h1_0000_0000)
			return 0;
		fit = (64'h1_0000_0000 - base_addr) / PAGE_BYTES;
		return (fit < PAGE_SLOTS) ? fit : PAGE_SLOTS;
	endfunction

	// Works out the response to one request and updates the slot map.
	function automatic outcome_t allocator_outcome(input request_t item);
		outcome_t        res;
		longint unsigned usable, base_addr, want, idx, run_len, run_head, k;
		longint unsigned lo, hi, fin, a;
		logic [63:0]     wide;
		res = '0;
		usable = usable_slots();
		base_addr = slot_base();
		if (item.op == OP_ALLOC) begin
			if (item.size <= small_bytes) begin
				res.status = STS_SMALL;
				return res;
			end
			a = item.size;
			want = (a + PAGE_BYTES - 1) / PAGE_BYTES;
			res.status = STS_NO_SPACE;
			if (want > usable)
				return res;
			// First fit: skip each used run by its recorded length.
			idx = 0;
			run_len = 0;
			run_head = 0;
			while (idx < usable) begin
				if (slot_taken[idx]) begin
					run_len = 0;
					idx += (slot_pages[idx] == 0) ? 1 : slot_pages[idx];
				end else begin
					if (run_len == 0)
						run_head = idx;
					run_len++;
					if (run_len == want) begin
						for (k = run_head; k < run_head + want; k++) begin
							slot_taken[k] = 1'b1;
							slot_head[k] = run_head;
							slot_pages[k] = want;
						end
						wide = base_addr + run_head * PAGE_BYTES;
						res.status = STS_ALLOCATED;
						res.address = wide[ADDR_W-1:0];
						res.pages = want;
						return res;
					end
					idx++;
				end
			end
			return res;
		end
		// Free by address: the block region is tested first.
		a = item.addr;
		lo = region_start;
		lo = lo * PAGE_BYTES;
		hi = region_limit;
		hi = hi * PAGE_BYTES;
		fin = base_addr + usable * PAGE_BYTES;
		if (a >= lo && a < hi) begin
			res.status = STS_BLOCK_FREE;
			return res;
		end
		if (a < base_addr || a >= fin) begin
			res.status = STS_INVALID;
			return res;
		end
		idx = (a - base_addr) / PAGE_BYTES;
		if (!slot_taken[idx]) begin
			res.status = STS_NOT_ALLOC;
			return res;
		end
		run_head = slot_head[idx];
		run_len = slot_pages[idx];
		for (k = run_head; k < run_head + run_len && k < PAGE_SLOTS; k++) begin
			slot_taken[k] = 1'b0;
			slot_head[k] = 0;
			slot_pages[k] = 0;
		end
		res.status = STS_FREED;
		res.pages = run_len;
		return res;
	endfunction

	// Random usable slot that is used or free as asked, or -1 if none.
	function automatic int pick_slot(input bit want_used);
		int          cand [$];
		int unsigned usable;
		usable = usable_slots();
		for (int i = 0; i < usable; i++)
			if (slot_taken[i] == want_used)
				cand.push_back(i);
		if (cand.size() == 0)
			return -1;
		return cand[$urandom_range(0, cand.size() - 1)];
	endfunction

	// Mostly allocations and frees of live runs, with some stray requests.
	function automatic request_t pick_random_request();
		request_t        item;
		logic [63:0]     wide;
		int unsigned     usable, npages, roll, kind, page;
		int              slot;
		longint unsigned base_addr;
		item = '0;
		item.op = OP_ALLOC;
		usable = usable_slots();
		base_addr = slot_base();
		roll = $urandom_range(0, 99);
		slot = pick_slot(1'b1);
		if (roll >= 45 && roll < 85 && slot >= 0) begin
			item.op = OP_FREE;
			wide = base_addr + longint'(slot) * PAGE_BYTES + $urandom_range(0, PAGE_BYTES - 1);
			item.addr = wide[ADDR_W-1:0];
		end else if (roll < 85) begin
			kind = $urandom_range(0, 99);
			if (kind < 80)
				npages = $urandom_range(1, 8);
			else if (kind < 97 || usable <= 65)
				npages = $urandom_range(9, 64);
			else
				npages = $urandom_range(65, usable);
			wide = longint'(npages) * PAGE_BYTES - $urandom_range(0, PAGE_BYTES - 1);
			item.size = wide[SIZE_W-1:0];
		end else begin
			item.op = OP_FREE;
			wide = '0;
			case ($urandom_range(0, 6))
				0: begin
					item.op = OP_ALLOC;
					item.size = $urandom;
				end
				1: wide = $urandom;
				2: begin
					if (region_start < region_limit) begin
						page = $urandom_range(region_start, region_limit - 1);
						wide = longint'(page) * PAGE_BYTES + $urandom_range(0, PAGE_BYTES - 1);
					end else begin
						wide = $urandom;
					end
				end
				3: wide = 64'(region_limit) * PAGE_BYTES + $urandom_range(0, PAGE_BYTES - 1);
				4: begin
					slot = pick_slot(1'b0);
					wide = base_addr + $urandom_range(0, PAGE_BYTES - 1);
					if (slot >= 0)
						wide = wide + longint'(slot) * PAGE_BYTES;
				end
				5: wide = base_addr + longint'(usable) * PAGE_BYTES +
					$urandom_range(0, PAGE_BYTES - 1);
				default: begin
					item.op = OP_ALLOC;
					item.size = $urandom_range(0, small_bytes);
				end
			endcase
			item.addr = wide[ADDR_W-1:0];
		end
		return item;
	endfunction

	task automatic report_mismatch(input string what);
		error_count++;
		if (error_count <= PRINT_LIMIT)
			$display("mismatch at %0t ns: %s", $time, what);
	endtask

	// Hands one request to the driver once the previous one has been taken,
	// so that free addresses are chosen from an up-to-date slot map.
	task automatic queue_request(input request_t item);
		while (request_backlog.size() != 0 || req.valid)
			@(negedge clk);
		request_backlog.push_back(item);
	endtask

	task automatic ask_alloc(input logic [SIZE_W-1:0] size);
		request_t item;
		item = '0;
		item.op = OP_ALLOC;
		item.size = size;
		queue_request(item);
	endtask

	task automatic ask_free(input logic [ADDR_W-1:0] addr);
		request_t item;
		item = '0;
		item.op = OP_FREE;
		item.addr = addr;
		queue_request(item);
	endtask

	// Register writes go in only once every response has come back.
	task automatic program_region(input logic [PAGE_NUM_W-1:0] start_page,
			input logic [PAGE_NUM_W-1:0] limit_page, input logic [SMALL_W-1:0] small_limit);
		while (request_backlog.size() != 0 || req.valid || awaited_results.size() != 0)
			@(negedge clk);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_BLOCK_START;
		cfg_wdata <= start_page;
		@(posedge clk);
		cfg_index <= CFG_BLOCK_LIMIT;
		cfg_wdata <= limit_page;
		@(posedge clk);
		cfg_index <= CFG_SMALL_LIMIT;
		cfg_wdata <= {{(CFG_DATA_W - SMALL_W){1'b0}}, small_limit};
		@(posedge clk);
		cfg_we <= 1'b0;
		region_start = start_page;
		region_limit = limit_page;
		small_bytes = small_limit;
	endtask

	// Each request is picked only after the previous one has been taken.
	task automatic run_random_phase(input int count);
		repeat (count) begin
			while (request_backlog.size() != 0 || req.valid)
				@(negedge clk);
			queue_request(pick_random_request());
		end
	endtask

	// Request driver: valid holds until the beat is taken.
	always @(posedge clk) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.operation <= OP_ALLOC;
			req.size_bytes <= '0;
			req.address <= '0;
		end else begin
			if (req.valid && req.ready) begin
				taken_beat.op = req.operation;
				taken_beat.size = req.size_bytes;
				taken_beat.addr = req.address;
				awaited_results.push_back(allocator_outcome(taken_beat));
				requests_taken++;
			end
			if (!req.valid || req.ready) begin
				if (request_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					next_beat = request_backlog.pop_front();
					req.valid <= 1'b1;
					req.operation <= next_beat.op;
					req.size_bytes <= next_beat.size;
					req.address <= next_beat.addr;
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// Response back-pressure.
	always @(posedge clk) begin
		if (!arst_n)
			rsp.ready <= 1'b0;
		else
			rsp.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// Response monitor: each beat is matched against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			status_seen[rsp.status]++;
			if (awaited_results.size() == 0) begin
				report_mismatch($sformatf("response beat with status %0d and no request outstanding",
					rsp.status));
			end else begin
				due_result = awaited_results.pop_front();
				results_checked++;
				if (rsp.status !== due_result.status)
					report_mismatch($sformatf("status %0d, expected %0d",
						rsp.status, due_result.status));
				if (rsp.result_address !== due_result.address)
					report_mismatch($sformatf("result_address %h, expected %h",
						rsp.result_address, due_result.address));
				if (rsp.pages_changed !== due_result.pages)
					report_mismatch($sformatf("pages_changed %0d, expected %0d",
						rsp.pages_changed, due_result.pages));
			end
		end
	end

	// Watchdog on cycles in which no beat moves on either channel.
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("no beat moved for %0d cycles", WATCHDOG_LIMIT);
			$display("testbench: errors");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_BLOCK_START;
		cfg_wdata <= '0;
		region_start = '0;
		region_limit = '0;
		small_bytes = SMALL_LIMIT_RST;
		send_idle_pct = 38;
		recv_idle_pct = 78;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: size edges, a full map and a request for a run over all slots.
		ask_alloc(32'd0);
		ask_alloc(32'd2048);
		ask_alloc(32'd2049);
		ask_alloc(32'hFFFF_FFFF);
		ask_alloc(32'd12288);
		ask_free(32'h0000_4FFF);
		ask_free(32'h0000_2000);
		ask_free(32'h0000_0000);
		ask_free(32'hFFFF_FFFF);
		ask_alloc(32'd1023 * PAGE_BYTES);
		ask_alloc(32'd2049);
		ask_free(32'h0000_1000);
		ask_free(32'h003F_F123);
		ask_alloc(32'h0040_0000);
		ask_alloc(32'h0040_0001);
		ask_free(32'h0040_0FFF);

		// Block region below the slots, and a small-size limit of zero.
		program_region(20'h00100, 20'h00200, 16'h0000);
		ask_alloc(32'd1);
		ask_free(32'h0010_0000);
		ask_free(32'h001F_FFFF);
		ask_free(32'h0020_0ABC);
		ask_free(32'h0020_1FFF);
		ask_alloc(32'd0);

		// Slots pushed wholly past the address space.
		program_region(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
		ask_alloc(32'h0001_0000);
		ask_alloc(32'h0001_0001);
		ask_free(32'hFFFF_FFFF);

		// Only ten slots fit below the top of the address space.
		program_region(20'h00000, 20'hFFFF5, 16'h07FF);
		ask_alloc(32'd10 * PAGE_BYTES);
		ask_free(32'h0000_0000);
		ask_free(32'hFFFF_FFFF);

		program_region(20'h00010, 20'h00080, 16'd2048);
		run_random_phase(PHASE_ITEMS);
		program_region($urandom_range(0, 16'h3FFF), $urandom_range(0, 16'h3FFF),
			$urandom_range(0, 16'hFFFF));
		run_random_phase(PHASE_ITEMS);

		send_idle_pct = 78;
		recv_idle_pct = 38;
		program_region(20'h00000, 20'hFFBFF, 16'hFFFF);
		run_random_phase(PHASE_ITEMS);
		program_region(20'h00003, 20'hFFFF0, 16'h0000);
		run_random_phase(PHASE_ITEMS);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		program_region(20'h00000, 20'h00000, 16'h0000);
		run_random_phase(PHASE_ITEMS);
		program_region($urandom_range(0, 16'h3FFF), $urandom_range(0, 16'h3FFF),
			$urandom_range(0, 16'hFFFF));
		run_random_phase(PHASE_ITEMS);

		// Drain, then allow a little longer for any stray response beat.
		while (request_backlog.size() != 0 || req.valid || awaited_results.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);

		$display("covered %0d requests and %0d responses: %0d runs placed, %0d runs released",
			requests_taken, results_checked, status_seen[STS_ALLOCATED], status_seen[STS_FREED]);
		$display("refused %0d for space, %0d small, %0d block region, %0d invalid, %0d unused slot",
			status_seen[STS_NO_SPACE], status_seen[STS_SMALL], status_seen[STS_BLOCK_FREE],
			status_seen[STS_INVALID], status_seen[STS_NOT_ALLOC]);
		if (error_count == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule

// File: filelist.f
hdl/cpa_pkg.sv
hdl/cpa_if.sv
hdl/cpa_slot_mem.sv
hdl/cpa_seq.sv
hdl/contiguous_page_allocator_top.sv
sim/testbench.sv
